/* rtl/kap_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kap_pkg
// Shared types, constants and helpers for the keypad autorepeat block.
// ----------------------------------------------------------------------------
package kap_pkg;

  localparam int NUM_KEYS_DEF   = 9;
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int ALT_KEY_DEF    = 9;

  localparam int REQ_W   = 2;
  localparam int PIN_W   = 9;
  localparam int MAP_W   = 9;
  localparam int NOW_W   = 32;
  localparam int CODE_W  = 8;
  localparam int MS_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W   = 16;
  localparam int US_PER_MS = 1000;

  localparam logic [MS_W-1:0] FIRST_MS_RST   = 16'd400;
  localparam logic [MS_W-1:0] REPEAT_MS_RST  = 16'd100;
  localparam logic [MS_W-1:0] RELEASE_MS_RST = 16'd50;

  typedef enum logic [REQ_W-1:0] {
    REQ_SCAN  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_PUSH  = 2'd3
  } kap_req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCAN_EN    = 2'd0,
    CFG_FIRST_MS   = 2'd1,
    CFG_REPEAT_MS  = 2'd2,
    CFG_RELEASE_MS = 2'd3
  } kap_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_EMIT
  } kap_state_t;

  // Timing context broadcast to every key cell during a scan.
  typedef struct packed {
    logic [NOW_W-1:0] now_us;
    logic [NOW_W-1:0] first_us;
    logic [NOW_W-1:0] repeat_us;
    logic [NOW_W-1:0] release_us;
  } kap_scan_t;

  // Per-cell status toward the top level.
  typedef struct packed {
    logic pressed;
    logic queue;
  } kap_cell_st_t;

  function automatic logic [NOW_W-1:0] ms_to_us(input logic [MS_W-1:0] ms);
    logic [NOW_W-1:0] prod;
    prod = {{(NOW_W-MS_W){1'b0}}, ms} * NOW_W'(US_PER_MS);
    return prod;
  endfunction

endpackage

/* rtl/kap_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kap_in_if
// Request channel: valid/ready handshake with the request word.
// ----------------------------------------------------------------------------
interface kap_in_if;
  logic                      valid;
  logic                      ready;
  logic [kap_pkg::REQ_W-1:0]  req_type;
  logic [kap_pkg::PIN_W-1:0]  key_pins;
  logic [kap_pkg::NOW_W-1:0]  now_us;
  logic [kap_pkg::CODE_W-1:0] pushed_code;

  modport source (output valid, req_type, key_pins, now_us, pushed_code, input ready);
  modport sink   (input valid, req_type, key_pins, now_us, pushed_code, output ready);
endinterface

/* rtl/kap_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kap_out_if
// Result channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
interface kap_out_if;
  logic                      valid;
  logic                      ready;
  logic [kap_pkg::CODE_W-1:0] code_out;
  logic                      code_valid;
  logic [kap_pkg::MAP_W-1:0]  pressed_map;
  logic                      none_pressed;

  modport source (output valid, code_out, code_valid, pressed_map, none_pressed,
                  input ready);
  modport sink   (input valid, code_out, code_valid, pressed_map, none_pressed,
                  output ready);
endinterface

/* rtl/kap_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/kap_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kap_cell
// One key of the scan chain: pressed flag, repeat and release timers.
// Active in the cycle the scan token reaches it, then hands the token on.
// ----------------------------------------------------------------------------
module kap_cell #(
  parameter bit IS_ALT = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tok_in,
  input  logic                  pin_down,
  input  kap_pkg::kap_scan_t    scan,
  output logic                  tok_out,
  output kap_pkg::kap_cell_st_t status
);
  import kap_pkg::*;

  logic             tok_r;
  logic             pressed_r, pressed_nxt;
  logic [NOW_W-1:0] nrt_r, nrt_nxt;
  logic [NOW_W-1:0] ldt_r, ldt_nxt;
  logic [NOW_W-1:0] since_nrt;
  logic [NOW_W-1:0] since_ldt;
  logic             queue;

  assign since_nrt = scan.now_us - nrt_r;
  assign since_ldt = scan.now_us - ldt_r;

  always_comb begin
    pressed_nxt = pressed_r;
    nrt_nxt     = nrt_r;
    ldt_nxt     = ldt_r;
    queue       = 1'b0;
    if (tok_in) begin
      if (pin_down) begin
        if (!pressed_r) begin
          pressed_nxt = 1'b1;
          nrt_nxt     = scan.now_us + scan.first_us;
          queue       = 1'b1;
        end else if (!IS_ALT && !since_nrt[NOW_W-1]) begin
          nrt_nxt = scan.now_us + scan.repeat_us;
          queue   = 1'b1;
        end
        ldt_nxt = scan.now_us;
      end else if (since_ldt >= scan.release_us) begin
        pressed_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r     <= 1'b0;
      pressed_r <= 1'b0;
      nrt_r     <= '0;
      ldt_r     <= '0;
    end else begin
      tok_r     <= tok_in;
      pressed_r <= pressed_nxt;
      nrt_r     <= nrt_nxt;
      ldt_r     <= ldt_nxt;
    end
  end

  assign tok_out        = tok_r;
  assign status.pressed = pressed_r;
  assign status.queue   = queue;

endmodule

/* rtl/keypad_autorepeat_fifo_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_autorepeat_fifo_top
// Keypad scanner with autorepeat, key-code ring FIFO and push-back slot.
// ----------------------------------------------------------------------------
// Scan tick: the token walks one key cell per cycle and each cell may write one
//   code into the ring RAM; the result follows once the token leaves the chain.
// Read from the ring passes the READ state (registered RAM read); others do not.
// One request in flight: a new word is taken only in the idle state; the
//   next is accepted while the result waits on out.
// rst_n (sync, active low) clears state and loads config defaults, not the ring.
module keypad_autorepeat_fifo_top #(
  parameter int NUM_KEYS       = kap_pkg::NUM_KEYS_DEF,
  parameter int FIFO_DEPTH     = kap_pkg::FIFO_DEPTH_DEF,
  parameter int ALT_KEY_NUMBER = kap_pkg::ALT_KEY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  kap_in_if.sink                        in_ch,
  kap_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [kap_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [kap_pkg::CFG_W-1:0]     cfg_data
);
  import kap_pkg::*;

  localparam int  PTR_W  = $clog2(FIFO_DEPTH);
  localparam int  KEY_W  = $clog2(NUM_KEYS + 1);
  localparam bit  ALT_OK = (ALT_KEY_NUMBER >= 1) && (ALT_KEY_NUMBER <= NUM_KEYS);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  // config
  logic            scan_en_r;
  logic [MS_W-1:0] first_ms_r, repeat_ms_r, release_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_en_r    <= 1'b0;
      first_ms_r   <= FIRST_MS_RST;
      repeat_ms_r  <= REPEAT_MS_RST;
      release_ms_r <= RELEASE_MS_RST;
    end else if (cfg_we) begin
      unique case (kap_cfg_t'(cfg_idx))
        CFG_SCAN_EN:    scan_en_r    <= cfg_data[0];
        CFG_FIRST_MS:   first_ms_r   <= cfg_data[MS_W-1:0];
        CFG_REPEAT_MS:  repeat_ms_r  <= cfg_data[MS_W-1:0];
        CFG_RELEASE_MS: release_ms_r <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  kap_state_t state_r, state_nxt;
  logic       fire;
  logic       in_ready;
  logic       load_out;
  logic       ram_re;
  kap_req_t   req;

  logic [PTR_W-1:0]  wp_r, rp_r, wp_inc, rp_inc;
  logic [CODE_W-1:0] pb_r;
  logic [CODE_W-1:0] res_code_r;
  logic              scan_go_r;
  logic [CODE_W-1:0] ram_rdata;
  logic              fifo_empty;
  logic              fifo_full;
  logic              out_valid_r;

  logic [NUM_KEYS:0]    tok;
  kap_cell_st_t         cell_st [NUM_KEYS];
  logic [NUM_KEYS-1:0]  pressed;
  logic [NUM_KEYS-1:0]  queue;
  logic [PIN_W-1:0]     pins_r;
  kap_scan_t            scan_r;

  assign req        = kap_req_t'(in_ch.req_type);
  assign wp_inc     = (wp_r == PTR_LAST) ? '0 : wp_r + PTR_W'(1);
  assign rp_inc     = (rp_r == PTR_LAST) ? '0 : rp_r + PTR_W'(1);
  assign fifo_empty = (rp_r == wp_r);
  assign fifo_full  = (wp_inc == rp_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (req == REQ_SCAN && scan_en_r) begin
            state_nxt = ST_SCAN;
          end else if (req == REQ_READ && pb_r == '0 && !fifo_empty) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        if (tok[NUM_KEYS]) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_READ: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    fire     = in_ready && in_ch.valid;
    ram_re   = fire && req == REQ_READ && pb_r == '0 && !fifo_empty;
    load_out = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  end

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      scan_go_r <= 1'b0;
      rp_r      <= '0;
      pb_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      scan_go_r <= fire && req == REQ_SCAN && scan_en_r;
      if (fire) begin
        unique case (req)
          REQ_SCAN: ;
          REQ_READ: begin
            if (pb_r != '0) begin
              pb_r <= '0;
            end else if (!fifo_empty) begin
              rp_r <= rp_inc;
            end
          end
          REQ_FLUSH: begin
            rp_r <= wp_r;
            pb_r <= '0;
          end
          REQ_PUSH: pb_r <= in_ch.pushed_code;
          default: ;
        endcase
      end
    end
  end

  // result code and scan context
  always_ff @(posedge clk) begin
    if (fire) begin
      res_code_r <= (req == REQ_READ) ? pb_r : '0;
      pins_r            <= in_ch.key_pins;
      scan_r.now_us     <= in_ch.now_us;
      scan_r.first_us   <= ms_to_us(first_ms_r);
      scan_r.repeat_us  <= ms_to_us(repeat_ms_r);
      scan_r.release_us <= ms_to_us(release_ms_r);
    end else if (state_r == ST_READ) begin
      res_code_r <= ram_rdata;
    end
  end

  // key cell chain
  assign tok[0] = scan_go_r;

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_cell
    logic pin_down;
    if (i < PIN_W) begin : g_pin
      assign pin_down = ~pins_r[i];
    end else begin : g_nopin
      assign pin_down = 1'b1;
    end
    kap_cell #(
      .IS_ALT (i + 1 == ALT_KEY_NUMBER)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   (tok[i]),
      .pin_down (pin_down),
      .scan     (scan_r),
      .tok_out  (tok[i+1]),
      .status   (cell_st[i])
    );
    assign pressed[i] = cell_st[i].pressed;
    assign queue[i]   = cell_st[i].queue;
  end

  // code of the key that queues this cycle
  logic              q_any;
  logic [KEY_W-1:0]  q_key;
  logic              alt_bit;
  logic [CODE_W-1:0] q_code;

  always_comb begin
    q_key = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (queue[k]) begin
        q_key = q_key | KEY_W'(k + 1);
      end
    end
  end

  assign q_any = |queue;

  if (ALT_OK) begin : g_alt
    // alt's own first press sees its freshly set flag
    assign alt_bit = pressed[ALT_KEY_NUMBER-1] | queue[ALT_KEY_NUMBER-1];
  end else begin : g_noalt
    assign alt_bit = 1'b0;
  end

  if (KEY_W >= CODE_W - 1) begin : g_code_trunc
    assign q_code = {alt_bit, q_key[CODE_W-2:0]};
  end else begin : g_code_ext
    assign q_code = {alt_bit, {(CODE_W-1-KEY_W){1'b0}}, q_key};
  end

  logic ram_we;
  assign ram_we = q_any && !fifo_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
    end else if (ram_we) begin
      wp_r <= wp_inc;
    end
  end

  kap_ram #(
    .WIDTH (CODE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (q_code),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  // output register
  logic [MAP_W-1:0] map;
  for (genvar b = 0; b < MAP_W; b++) begin : g_map
    if (b < NUM_KEYS) begin : g_on
      assign map[b] = pressed[b];
    end else begin : g_off
      assign map[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  logic [CODE_W-1:0] code_out_r;
  logic              code_valid_r;
  logic [MAP_W-1:0]  map_r;
  logic              none_r;

  always_ff @(posedge clk) begin
    if (load_out) begin
      code_out_r   <= res_code_r;
      code_valid_r <= (res_code_r != '0);
      map_r        <= map;
      none_r       <= ~|pressed;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.code_out     = code_out_r;
  assign out_ch.code_valid   = code_valid_r;
  assign out_ch.pressed_map  = map_r;
  assign out_ch.none_pressed = none_r;

`ifndef SYNTH
  a_one_queue: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(queue))
    else $error("more than one key queued in a cycle");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok))
    else $error("more than one scan token in the chain");

  a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> tok[NUM_KEYS:1] == '0)
    else $error("scan token alive while idle");

  a_scan_rp_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |=> $stable(rp_r))
    else $error("read pointer moved during a scan");

  a_emit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> state_r == ST_READ)
    else $error("ring read without read state");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keypad_autorepeat_fifo_top.
// A scoreboard class keeps its own key flags, repeat and release timers, code
// ring and push-back slot. It predicts one result word per accepted request and
// compares every field. A directed part covers the corner cases. Randomized
// phases follow, each with its own timing registers. They drive held-key
// sequences with noise; all phases but one add random gaps on both channels.
// The bench also forces one long output stall and one full drain mid-phase.
// ----------------------------------------------------------------------------
module testbench;
  import kap_pkg::*;

  localparam int KEYS     = NUM_KEYS_DEF;
  localparam int DEPTH    = FIFO_DEPTH_DEF;
  localparam int ALT      = ALT_KEY_DEF;
  localparam int SCAN_LAT = KEYS + 3;
  localparam logic [CODE_W-1:0] ALT_BIT = 8'h80;

  typedef struct {
    kap_req_t          req;
    logic [PIN_W-1:0]  pins;
    logic [NOW_W-1:0]  now;
    logic [CODE_W-1:0] pushed;
  } key_req_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              code_valid;
    logic [MAP_W-1:0]  map;
    logic              none;
  } key_result_t;

  class key_code_board;
    bit                scan_en;
    bit [MS_W-1:0]     first_ms, repeat_ms, release_ms;
    bit                key_held[KEYS];
    bit [NOW_W-1:0]    repeat_due[KEYS];
    bit [NOW_W-1:0]    last_down[KEYS];
    bit [CODE_W-1:0]   ring[DEPTH];
    int                wr_ptr, rd_ptr;
    bit [CODE_W-1:0]   slot;
    key_result_t       expected_q[$];
    int                errors;

    function new();
      scan_en    = 1'b0;
      first_ms   = FIRST_MS_RST;
      repeat_ms  = REPEAT_MS_RST;
      release_ms = RELEASE_MS_RST;
      foreach (key_held[i]) begin
        key_held[i]   = 1'b0;
        repeat_due[i] = '0;
        last_down[i]  = '0;
      end
      wr_ptr = 0;
      rd_ptr = 0;
      slot   = '0;
      errors = 0;
    endfunction

    function void write_reg(kap_cfg_t idx, bit [CFG_W-1:0] v);
      case (idx)
        CFG_SCAN_EN:    scan_en    = v[0];
        CFG_FIRST_MS:   first_ms   = v;
        CFG_REPEAT_MS:  repeat_ms  = v;
        CFG_RELEASE_MS: release_ms = v;
        default: ;
      endcase
    endfunction

    function bit [NOW_W-1:0] to_us(bit [MS_W-1:0] ms);
      return NOW_W'(ms) * NOW_W'(US_PER_MS);
    endfunction

    function void push_code(int key);
      int nxt;
      bit [CODE_W-1:0] c;
      nxt = (wr_ptr + 1) % DEPTH;
      if (nxt == rd_ptr) return;
      c = CODE_W'(key) & 8'h7f;
      if (ALT >= 1 && ALT <= KEYS && key_held[ALT-1]) c |= ALT_BIT;
      ring[wr_ptr] = c;
      wr_ptr = nxt;
    endfunction

    function void scan(bit [PIN_W-1:0] pins, bit [NOW_W-1:0] now);
      bit [NOW_W-1:0] lag;
      for (int i = 0; i < KEYS; i++) begin
        if (!pins[i]) begin
          if (!key_held[i]) begin
            key_held[i]   = 1'b1;
            repeat_due[i] = now + to_us(first_ms);
            push_code(i + 1);
          end else if (i + 1 != ALT) begin
            lag = now - repeat_due[i];
            if (!lag[NOW_W-1]) begin
              repeat_due[i] = now + to_us(repeat_ms);
              push_code(i + 1);
            end
          end
          last_down[i] = now;
        end else begin
          lag = now - last_down[i];
          if (lag >= to_us(release_ms)) key_held[i] = 1'b0;
        end
      end
    endfunction

    function bit [CODE_W-1:0] pop_code();
      bit [CODE_W-1:0] c;
      if (slot != 0) begin
        c    = slot;
        slot = '0;
        return c;
      end
      if (rd_ptr == wr_ptr) return '0;
      c      = ring[rd_ptr];
      rd_ptr = (rd_ptr + 1) % DEPTH;
      return c;
    endfunction

    function void accept_request(key_req_t rq);
      key_result_t r;
      r.code = '0;
      case (rq.req)
        REQ_SCAN:  if (scan_en) scan(rq.pins, rq.now);
        REQ_READ:  r.code = pop_code();
        REQ_FLUSH: begin
          rd_ptr = wr_ptr;
          slot   = '0;
        end
        REQ_PUSH:  slot = rq.pushed;
        default: ;
      endcase
      r.code_valid = (r.code != 0);
      r.map        = '0;
      for (int i = 0; i < KEYS; i++) r.map[i] = key_held[i];
      r.none = (r.map == 0);
      expected_q.push_back(r);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(key_result_t got);
      key_result_t want;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: code_out=%0h", got.code);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("code_out", want.code, got.code);
      compare("code_valid", want.code_valid, got.code_valid);
      compare("pressed_map", want.map, got.map);
      compare("none_pressed", want.none, got.none);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  bit                   no_gaps;
  bit                   rx_hold_req;
  key_code_board        board;

  kap_in_if  in_ch ();
  kap_out_if out_ch ();

  keypad_autorepeat_fifo_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // result side: random ready, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    key_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.code       = out_ch.code_out;
      got.code_valid = out_ch.code_valid;
      got.map        = out_ch.pressed_map;
      got.none       = out_ch.none_pressed;
      board.check_result(got);
    end
  end

  task automatic send(input kap_req_t req, input logic [PIN_W-1:0] pins,
                      input logic [NOW_W-1:0] now, input logic [CODE_W-1:0] pushed);
    key_req_t rq;
    rq.req    = req;
    rq.pins   = pins;
    rq.now    = now;
    rq.pushed = pushed;
    while (!no_gaps && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= req;
    in_ch.key_pins    <= pins;
    in_ch.now_us      <= now;
    in_ch.pushed_code <= pushed;
    do @(posedge clk); while (!in_ch.ready);
    board.accept_request(rq);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (board.pending() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SCAN_LAT + 4) @(posedge clk);
  endtask

  task automatic set_config(input bit en_v, input logic [MS_W-1:0] first_v,
                            input logic [MS_W-1:0] rep_v, input logic [MS_W-1:0] rel_v);
    kap_cfg_t         regs [4];
    logic [CFG_W-1:0] vals [4];
    regs = '{CFG_SCAN_EN, CFG_FIRST_MS, CFG_REPEAT_MS, CFG_RELEASE_MS};
    vals = '{CFG_W'(en_v), first_v, rep_v, rel_v};
    drain();
    for (int k = 0; k < 4; k++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= regs[k];
      cfg_data <= vals[k];
      @(posedge clk);
      board.write_reg(regs[k], vals[k]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int count, input int step_lo, input int step_hi,
                           input bit near_wrap, input bit do_hold, input bit do_pause);
    logic [PIN_W-1:0] down;
    logic [PIN_W-1:0] pins;
    logic [NOW_W-1:0] now;
    int               pick;
    down = '0;
    now  = near_wrap ? 32'hFFFF_FFFF - $urandom_range(0, 50000) : $urandom;
    for (int n = 0; n < count; n++) begin
      if (do_hold && n == count / 2) rx_hold_req = 1'b1;
      if (do_pause && n == count / 3) drain();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if ($urandom_range(0, 99) < 5) begin
          send(REQ_SCAN, PIN_W'($urandom), $urandom, CODE_W'($urandom));
        end else begin
          now += $urandom_range(step_lo, step_hi);
          if ($urandom_range(0, 99) < 15) begin
            case ($urandom_range(0, 3))
              0: down = '0;
              1: down ^= PIN_W'(1) << $urandom_range(0, KEYS - 1);
              2: down = PIN_W'($urandom);
              default: down = (PIN_W'(1) << (ALT - 1)) |
                              (PIN_W'(1) << $urandom_range(0, KEYS - 2));
            endcase
          end
          pins = ~down;
          // short bounce on one pin
          if ($urandom_range(0, 99) < 5) pins[$urandom_range(0, PIN_W - 1)] ^= 1'b1;
          send(REQ_SCAN, pins, now, CODE_W'($urandom));
        end
      end else if (pick < 85) begin
        send(REQ_READ, PIN_W'($urandom), $urandom, CODE_W'($urandom));
      end else if (pick < 93) begin
        send(REQ_PUSH, PIN_W'($urandom), $urandom,
             ($urandom_range(0, 4) == 0) ? CODE_W'(0) : CODE_W'($urandom));
      end else begin
        send(REQ_FLUSH, PIN_W'($urandom), $urandom, CODE_W'($urandom));
      end
    end
  endtask

  initial begin
    board = new();
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_SCAN_EN;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_SCAN;
    in_ch.key_pins    <= '0;
    in_ch.now_us      <= '0;
    in_ch.pushed_code <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // scan disabled, empty reads, push-back slot
    send(REQ_SCAN, 9'h000, 32'h0, 8'h00);
    send(REQ_READ, 9'h1FF, 32'h0, 8'h00);
    send(REQ_PUSH, 9'h000, 32'h0, 8'hFF);
    send(REQ_READ, 9'h000, 32'h0, 8'h00);
    send(REQ_PUSH, 9'h000, 32'h0, 8'h00);
    send(REQ_READ, 9'h000, 32'h0, 8'h00);

    set_config(1'b1, 16'd0, 16'd0, 16'd0);
    send(REQ_SCAN, 9'h000, 32'hFFFF_FFFF, 8'h00);
    send(REQ_PUSH, 9'h000, 32'h0, 8'h81);
    send(REQ_READ, 9'h000, 32'h0, 8'h00);
    send(REQ_READ, 9'h000, 32'h0, 8'h00);
    send(REQ_SCAN, 9'h1FF, 32'h0, 8'h00);
    // alt alone, then key 1 under alt, then its repeat
    send(REQ_SCAN, 9'h0FF, 32'd5, 8'h00);
    send(REQ_SCAN, 9'h0FE, 32'd6, 8'h00);
    send(REQ_SCAN, 9'h0FE, 32'd7, 8'h00);
    send(REQ_FLUSH, 9'h000, 32'h0, 8'h00);
    send(REQ_READ, 9'h000, 32'h0, 8'h00);
    // overfill the ring
    for (int k = 0; k < 3; k++) send(REQ_SCAN, 9'h000, 32'd8 + k, 8'h00);
    send(REQ_READ, 9'h000, 32'h0, 8'h00);
    send(REQ_READ, 9'h000, 32'h0, 8'h00);
    send(REQ_FLUSH, 9'h000, 32'h0, 8'h00);
    send(REQ_READ, 9'h000, 32'h0, 8'h00);

    set_config(1'b1, 16'd400, 16'd100, 16'd50);
    run_phase(160, 2000, 40000, 1'b0, 1'b0, 1'b1);
    set_config(1'b1, 16'd0, 16'd0, 16'd0);
    run_phase(160, 0, 2000, 1'b0, 1'b1, 1'b0);
    set_config(1'b1, 16'd3, 16'd1, 16'd2);
    no_gaps = 1'b1;
    run_phase(160, 300, 1500, 1'b0, 1'b0, 1'b0);
    set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    no_gaps = 1'b0;
    run_phase(160, 100000, 5000000, 1'b0, 1'b0, 1'b0);
    set_config(1'b0, 16'd20, 16'd5, 16'd10);
    run_phase(40, 500, 3000, 1'b0, 1'b0, 1'b0);
    set_config(1'b1, 16'd20, 16'd5, 16'd10);
    run_phase(200, 500, 3000, 1'b1, 1'b0, 1'b0);
    set_config(1'b1, 16'd1, 16'hFFFF, 16'd0);
    run_phase(160, 1000, 3000, 1'b0, 1'b0, 1'b0);

    drain();
    if (board.pending() != 0) begin
      $error("%0d result words never arrived", board.pending());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
